>>> hdl/ultrasonic_level_ranger_assert.svh
// Assertion helpers for the checker file.
`ifndef ULTRASONIC_LEVEL_RANGER_ASSERT_SVH
`define ULTRASONIC_LEVEL_RANGER_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define ULR_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ulr assertion failed");

// Next-cycle implication, sampled on clk_i, off during reset.
`define ULR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ulr assertion failed");

`endif

>>> hdl/ulr_pkg.sv
`timescale 1ns / 1ps
package ulr_pkg;

  localparam int unsigned COUNT_BITS_DEF = 16;

  // APB register map: one 32-bit register every 4 bytes
  localparam int unsigned APB_ADDR_W = 4;
  localparam int unsigned APB_DATA_W = 32;

  localparam logic [1:0] REG_TRIG_TICKS  = 2'd0;
  localparam logic [1:0] REG_ECHO_TMO    = 2'd1;
  localparam logic [1:0] REG_TANK_HEIGHT = 2'd2;
  localparam logic [1:0] REG_HALF_SPEED  = 2'd3;

  localparam logic [7:0]  TRIG_TICKS_RST  = 8'd10;
  localparam logic [15:0] ECHO_TMO_RST    = 16'd40000;
  localparam logic [7:0]  TANK_HEIGHT_RST = 8'd50;
  localparam logic [15:0] HALF_SPEED_RST  = 16'd1124;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_NEG     = 2'd1;
  localparam logic [1:0] STATUS_TIMEOUT = 2'd2;

  // Upper level bound of bands 0 to 4, in cm; band 5 takes every higher level
  localparam logic [7:0] BAND0_MAX = 8'd2;
  localparam logic [7:0] BAND1_MAX = 8'd10;
  localparam logic [7:0] BAND2_MAX = 8'd25;
  localparam logic [7:0] BAND3_MAX = 8'd35;
  localparam logic [7:0] BAND4_MAX = 8'd46;

  localparam logic [2:0] BAND_0   = 3'd0;
  localparam logic [2:0] BAND_1   = 3'd1;
  localparam logic [2:0] BAND_2   = 3'd2;
  localparam logic [2:0] BAND_3   = 3'd3;
  localparam logic [2:0] BAND_4   = 3'd4;
  localparam logic [2:0] BAND_5   = 3'd5;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_TRIG,
    PH_WAIT,
    PH_ECHO
  } phase_e;

  typedef struct packed {
    logic start_request;
    logic echo_level;
  } ulr_in_t;

  typedef struct packed {
    logic        trigger_level;
    logic        result_valid;
    logic [2:0]  level_band;
    logic [1:0]  status;
    logic [15:0] echo_width;
  } ulr_out_t;

  // Per-tick event from the sequencer
  typedef struct packed {
    logic trig;
    logic done;
    logic timeout;
  } ulr_evt_t;

endpackage

>>> hdl/ulr_seq.sv
`timescale 1ns / 1ps
module ulr_seq #(
  parameter int unsigned CountBits = ulr_pkg::COUNT_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 advance_i,
  input  ulr_pkg::ulr_in_t     tick_i,
  input  logic [7:0]           trig_ticks_i,
  input  logic [15:0]          echo_tmo_i,
  output ulr_pkg::ulr_evt_t    evt_o,
  output logic [CountBits-1:0] count_o
);

  localparam int unsigned WideW = (CountBits > 16) ? CountBits : 16;
  localparam logic [CountBits-1:0] CntMax = '1;
  localparam logic [CountBits-1:0] CntOne = CountBits'(1);

  ulr_pkg::phase_e      phase_q, phase_d;
  logic [CountBits-1:0] count_q, count_d;
  logic [CountBits-1:0] cnt_inc;
  logic                 trig_hit;
  logic                 tmo_hit;
  logic                 start_hit;

  // Saturating increment and its limit checks
  assign cnt_inc   = (count_q == CntMax) ? count_q : count_q + CntOne;
  assign trig_hit  = (WideW'(cnt_inc) >= WideW'(trig_ticks_i)) || (cnt_inc == CntMax);
  assign tmo_hit   = (WideW'(cnt_inc) >= WideW'(echo_tmo_i)) || (cnt_inc == CntMax);
  assign start_hit = (WideW'(CntOne) >= WideW'(trig_ticks_i));

  always_comb begin
    phase_d = phase_q;
    count_d = count_q;
    unique case (phase_q)
      ulr_pkg::PH_IDLE: begin
        if (tick_i.start_request) begin
          if (start_hit) begin
            phase_d = ulr_pkg::PH_WAIT;
            count_d = '0;
          end else begin
            phase_d = ulr_pkg::PH_TRIG;
            count_d = CntOne;
          end
        end
      end
      ulr_pkg::PH_TRIG: begin
        count_d = cnt_inc;
        if (trig_hit) begin
          phase_d = ulr_pkg::PH_WAIT;
          count_d = '0;
        end
      end
      ulr_pkg::PH_WAIT: begin
        if (tick_i.echo_level) begin
          phase_d = ulr_pkg::PH_ECHO;
          count_d = CntOne;
        end else if (tmo_hit) begin
          phase_d = ulr_pkg::PH_IDLE;
          count_d = '0;
        end else begin
          count_d = cnt_inc;
        end
      end
      ulr_pkg::PH_ECHO: begin
        if (!tick_i.echo_level || tmo_hit) begin
          phase_d = ulr_pkg::PH_IDLE;
          count_d = '0;
        end else begin
          count_d = cnt_inc;
        end
      end
      default: begin
        phase_d = ulr_pkg::PH_IDLE;
        count_d = '0;
      end
    endcase
  end

  always_comb begin
    evt_o   = '0;
    count_o = cnt_inc;
    unique case (phase_q)
      ulr_pkg::PH_IDLE: begin
        evt_o.trig = tick_i.start_request;
      end
      ulr_pkg::PH_TRIG: begin
        evt_o.trig = 1'b1;
      end
      ulr_pkg::PH_WAIT: begin
        evt_o.done    = !tick_i.echo_level && tmo_hit;
        evt_o.timeout = !tick_i.echo_level && tmo_hit;
      end
      ulr_pkg::PH_ECHO: begin
        evt_o.done    = !tick_i.echo_level || tmo_hit;
        evt_o.timeout = tick_i.echo_level && tmo_hit;
        // falling edge reports the width counted so far
        if (!tick_i.echo_level) begin
          count_o = count_q;
        end
      end
      default: begin
        evt_o = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= ulr_pkg::PH_IDLE;
      count_q <= '0;
    end else if (advance_i) begin
      phase_q <= phase_d;
      count_q <= count_d;
    end
  end

endmodule

>>> hdl/ulr_classify.sv
`timescale 1ns / 1ps
module ulr_classify #(
  parameter int unsigned CountBits = ulr_pkg::COUNT_BITS_DEF
) (
  input  ulr_pkg::ulr_evt_t    evt_i,
  input  logic [CountBits-1:0] count_i,
  input  logic [7:0]           tank_height_i,
  input  logic [15:0]          half_speed_i,
  input  logic [2:0]           last_band_i,
  input  logic [1:0]           last_status_i,
  output logic [2:0]           band_o,
  output logic [1:0]           status_o,
  output logic [15:0]          width_o
);

  localparam int unsigned ProdW = CountBits + 16;
  localparam int unsigned ExtW  = ProdW + 1;
  localparam int unsigned WideW = (CountBits > 16) ? CountBits : 16;

  logic [ProdW-1:0] dist_raw;
  logic [ExtW-1:0]  dist_e;
  logic [ExtW-1:0]  top_e;
  logic [ExtW-1:0]  diff_e;
  logic             below;
  logic             deep;
  logic [7:0]       level;
  logic [2:0]       band;
  logic [WideW-1:0] count_w;

  // Distance in Q16 cm, tank top in Q16 cm
  assign dist_raw = ProdW'(count_i) * ProdW'(half_speed_i);
  assign dist_e   = ExtW'(dist_raw);
  assign top_e    = ExtW'({tank_height_i, 16'h0000});
  assign diff_e   = top_e - dist_e;
  assign below    = dist_e > top_e;
  assign deep     = dist_e >= (top_e + ExtW'(17'h10000));
  assign level    = below ? 8'd0 : diff_e[23:16];

  always_comb begin
    if (level <= ulr_pkg::BAND0_MAX) begin
      band = ulr_pkg::BAND_0;
    end else if (level <= ulr_pkg::BAND1_MAX) begin
      band = ulr_pkg::BAND_1;
    end else if (level <= ulr_pkg::BAND2_MAX) begin
      band = ulr_pkg::BAND_2;
    end else if (level <= ulr_pkg::BAND3_MAX) begin
      band = ulr_pkg::BAND_3;
    end else if (level <= ulr_pkg::BAND4_MAX) begin
      band = ulr_pkg::BAND_4;
    end else begin
      band = ulr_pkg::BAND_5;
    end
  end

  always_comb begin
    band_o   = last_band_i;
    status_o = last_status_i;
    if (evt_i.done) begin
      if (evt_i.timeout) begin
        band_o   = ulr_pkg::BAND_0;
        status_o = ulr_pkg::STATUS_TIMEOUT;
      end else if (deep) begin
        band_o   = ulr_pkg::BAND_0;
        status_o = ulr_pkg::STATUS_NEG;
      end else begin
        band_o   = band;
        status_o = ulr_pkg::STATUS_OK;
      end
    end
  end

  // Saturate the reported width to 16 bits
  assign count_w = WideW'(count_i);
  always_comb begin
    width_o = '0;
    if (evt_i.done) begin
      width_o = (count_w > WideW'(16'hFFFF)) ? 16'hFFFF : count_w[15:0];
    end
  end

endmodule

>>> hdl/ultrasonic_level_ranger.sv
`timescale 1ns / 1ps
// Ultrasonic level ranger: trigger / echo controller for an HC-SR04 style sensor.
// Input channel (in_valid_i / in_ready_o / in_data_i): one request per
// microsecond tick, carrying start_request and the sampled echo pin level.
// Output channel (out_valid_o / out_ready_i / out_data_o): one result per
// request: trigger pin level, a result_valid flag on the tick a measurement
// ends, the held level band and status, and the echo width in ticks.
// APB port sets trigger length, echo timeout, tank height and the Q16 cm per
// tick factor; write it only while no request is in flight.
// Path: a result goes from the sequencer step into the event register, then
// through classification into the output register. Throughput: one request
// per cycle while out_ready_i does not stall the output, set by the
// sequencer step and the one 16-bit-factor multiply in the classify stage.
// Stall: the event register and output register hold two results, so one
// request is still taken while a finished result waits on out_ready_i.
// Reset: sequencer goes idle with a zero count, band and status read zero,
// registers take their default values. No clearing pass is needed.
module ultrasonic_level_ranger #(
  parameter int unsigned CountBits = ulr_pkg::COUNT_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  ulr_pkg::ulr_in_t                in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output ulr_pkg::ulr_out_t               out_data_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [ulr_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [ulr_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [ulr_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready
);

  // Configuration registers
  logic [7:0]  trig_ticks_q;
  logic [15:0] echo_tmo_q;
  logic [7:0]  tank_height_q;
  logic [15:0] half_speed_q;
  logic [1:0]  reg_idx;
  logic        cfg_wr;

  // Handshake and stage control
  logic in_fire;
  logic s1_move;
  logic out_move;

  // Sequencer outputs and event register
  ulr_pkg::ulr_evt_t    evt;
  logic [CountBits-1:0] evt_count;
  logic                 s1_valid_q;
  ulr_pkg::ulr_evt_t    s1_evt_q;
  logic [CountBits-1:0] s1_count_q;

  // Classification results and output register
  logic [2:0]        band_d;
  logic [1:0]        status_d;
  logic [15:0]       width_d;
  logic [2:0]        last_band_q;
  logic [1:0]        last_status_q;
  logic              out_valid_q;
  ulr_pkg::ulr_out_t out_data_q;

  // ---------------------------------------------------------------------------
  // APB register file: zero-wait, write on the access phase
  // ---------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trig_ticks_q  <= ulr_pkg::TRIG_TICKS_RST;
      echo_tmo_q    <= ulr_pkg::ECHO_TMO_RST;
      tank_height_q <= ulr_pkg::TANK_HEIGHT_RST;
      half_speed_q  <= ulr_pkg::HALF_SPEED_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        ulr_pkg::REG_TRIG_TICKS:  trig_ticks_q  <= pwdata[7:0];
        ulr_pkg::REG_ECHO_TMO:    echo_tmo_q    <= pwdata[15:0];
        ulr_pkg::REG_TANK_HEIGHT: tank_height_q <= pwdata[7:0];
        ulr_pkg::REG_HALF_SPEED:  half_speed_q  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      ulr_pkg::REG_TRIG_TICKS:  prdata = ulr_pkg::APB_DATA_W'(trig_ticks_q);
      ulr_pkg::REG_ECHO_TMO:    prdata = ulr_pkg::APB_DATA_W'(echo_tmo_q);
      ulr_pkg::REG_TANK_HEIGHT: prdata = ulr_pkg::APB_DATA_W'(tank_height_q);
      ulr_pkg::REG_HALF_SPEED:  prdata = ulr_pkg::APB_DATA_W'(half_speed_q);
      default:                  prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Flow control: output register drains first, the event register moves into
  // it, and a new request enters whenever the event register is free or moving.
  // ---------------------------------------------------------------------------
  assign out_move   = !out_valid_q || out_ready_i;
  assign s1_move    = s1_valid_q && out_move;
  assign in_ready_o = !s1_valid_q || out_move;
  assign in_fire    = in_valid_i && in_ready_o;

  // Sequencer: one state step per accepted request
  ulr_seq #(
    .CountBits(CountBits)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .advance_i   (in_fire),
    .tick_i      (in_data_i),
    .trig_ticks_i(trig_ticks_q),
    .echo_tmo_i  (echo_tmo_q),
    .evt_o       (evt),
    .count_o     (evt_count)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_fire) begin
      s1_valid_q <= 1'b1;
    end else if (s1_move) begin
      s1_valid_q <= 1'b0;
    end
  end

  // Capture the event with the count to report
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_evt_q   <= evt;
      s1_count_q <= evt_count;
    end
  end

  // Classify: distance, level, band and status for a finished measurement
  ulr_classify #(
    .CountBits(CountBits)
  ) u_classify (
    .evt_i        (s1_evt_q),
    .count_i      (s1_count_q),
    .tank_height_i(tank_height_q),
    .half_speed_i (half_speed_q),
    .last_band_i  (last_band_q),
    .last_status_i(last_status_q),
    .band_o       (band_d),
    .status_o     (status_d),
    .width_o      (width_d)
  );

  // Band and status stay on the outputs until the next measurement ends
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_band_q   <= ulr_pkg::BAND_0;
      last_status_q <= ulr_pkg::STATUS_OK;
      out_valid_q   <= 1'b0;
    end else begin
      if (s1_move) begin
        last_band_q   <= band_d;
        last_status_q <= status_d;
        out_valid_q   <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q   <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      out_data_q.trigger_level <= s1_evt_q.trig;
      out_data_q.result_valid  <= s1_evt_q.done;
      out_data_q.level_band    <= band_d;
      out_data_q.status        <= status_d;
      out_data_q.echo_width    <= width_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

>>> hdl/ulr_checker.sv
`timescale 1ns / 1ps
`include "ultrasonic_level_ranger_assert.svh"
module ulr_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input ulr_pkg::ulr_out_t out_data_o
);

  logic trig_done;
  logic width_zero;
  logic out_err;

  assign trig_done  = out_data_o.trigger_level && out_data_o.result_valid;
  assign width_zero = (out_data_o.echo_width == 16'h0000);
  assign out_err    = (out_data_o.status == ulr_pkg::STATUS_TIMEOUT) ||
                      (out_data_o.status == ulr_pkg::STATUS_NEG);

  // Stalled result holds
  `ULR_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o))

  // Trigger is never driven on the tick a measurement ends
  `ULR_ASSERT_IMPL(a_trig_not_done, out_valid_o, !trig_done)

  // Width is reported only with a finished measurement
  `ULR_ASSERT_IMPL(a_width_idle, out_valid_o && !out_data_o.result_valid, width_zero)

  // Error statuses carry band zero
  `ULR_ASSERT_IMPL(a_err_band, out_valid_o && out_err, out_data_o.level_band == ulr_pkg::BAND_0)

endmodule

bind ultrasonic_level_ranger ulr_checker u_ulr_checker (.*);

>>> test/tb_top.sv
`timescale 1ns / 1ps
// Checks the level ranger one tick at a time against a behavioral model:
// every accepted tick request predicts one result (trigger level, finish flag,
// held band and status, echo width), and the results are compared in order.
module tb_top;
  import ulr_pkg::*;

  localparam longint unsigned COUNT_MAX = (64'd1 << COUNT_BITS_DEF) - 64'd1;
  localparam int STALL_CYCLES   = 300;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASE_TICKS    = 100;
  localparam int RANDOM_PHASES  = 9;
  localparam int TAIL_CYCLES    = 10;
  localparam int PRINT_LIMIT    = 40;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_r  = 1'b0;
  logic                  in_ready;
  ulr_in_t               in_data_r   = '0;
  logic                  out_valid;
  logic                  out_ready_r = 1'b0;
  ulr_out_t              out_data;
  logic                  psel        = 1'b0;
  logic                  penable     = 1'b0;
  logic                  pwrite      = 1'b0;
  logic [APB_ADDR_W-1:0] paddr       = '0;
  logic [APB_DATA_W-1:0] pwdata      = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  // Tick requests waiting to be offered, and results predicted but not yet seen
  ulr_in_t  tick_backlog[$];
  ulr_out_t predicted_results[$];

  int ticks_offered = 0;
  int ticks_taken   = 0;
  int phase_ticks   = 0;
  int error_count   = 0;
  int send_idle_pct = 0;
  int rx_idle_pct   = 0;
  bit rx_stall      = 1'b0;
  logic in_fire     = 1'b0;

  // Model copy of the configuration registers
  logic [7:0]  cfg_trig    = TRIG_TICKS_RST;
  logic [15:0] cfg_timeout = ECHO_TMO_RST;
  logic [7:0]  cfg_tank    = TANK_HEIGHT_RST;
  logic [15:0] cfg_speed   = HALF_SPEED_RST;

  // Model copy of the sequencer state
  phase_e          rng_phase  = PH_IDLE;
  longint unsigned rng_count  = 0;
  logic [2:0]      rng_band   = BAND_0;
  logic [1:0]      rng_status = STATUS_OK;

  ultrasonic_level_ranger dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_r),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data_r),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready_r),
    .out_data_o  (out_data),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Saturating tick counter, COUNT_BITS_DEF wide
  function automatic longint unsigned count_inc(input longint unsigned c);
    return (c >= COUNT_MAX) ? COUNT_MAX : c + 64'd1;
  endfunction

  // A wait ends once the count reaches the timeout or the counter ceiling
  function automatic bit expired(input longint unsigned c);
    return (c >= cfg_timeout) || (c >= COUNT_MAX);
  endfunction

  // Turn an echo width into a level band, or flag the level as negative
  task automatic classify_width(input longint unsigned width);
    longint unsigned dist_q16;
    longint unsigned top;
    longint unsigned level;
    dist_q16 = width * cfg_speed;
    top      = cfg_tank;
    top      = top << 16;
    if (dist_q16 > top && dist_q16 - top >= 64'd65536) begin
      rng_band   = BAND_0;
      rng_status = STATUS_NEG;
    end else begin
      // Anything between -1 cm and 0 cm truncates to a zero level
      level = (dist_q16 > top) ? 64'd0 : (top - dist_q16) >> 16;
      if (level <= BAND0_MAX) rng_band = BAND_0;
      else if (level <= BAND1_MAX) rng_band = BAND_1;
      else if (level <= BAND2_MAX) rng_band = BAND_2;
      else if (level <= BAND3_MAX) rng_band = BAND_3;
      else if (level <= BAND4_MAX) rng_band = BAND_4;
      else rng_band = BAND_5;
      rng_status = STATUS_OK;
    end
  endtask

  // Advance the model by one tick and return the result it produces
  task automatic ranger_step(input ulr_in_t req, output ulr_out_t res);
    logic trig;
    logic timeout_hit;
    logic echo_fell;
    trig        = 1'b0;
    timeout_hit = 1'b0;
    echo_fell   = 1'b0;
    res         = '0;
    case (rng_phase)
      PH_IDLE: begin
        // The start tick is already the first trigger-high tick; a length
        // of zero behaves as one
        if (req.start_request) begin
          trig = 1'b1;
          if (cfg_trig <= 8'd1) begin
            rng_phase = PH_WAIT;
            rng_count = 0;
          end else begin
            rng_phase = PH_TRIG;
            rng_count = 1;
          end
        end
      end
      PH_TRIG: begin
        trig      = 1'b1;
        rng_count = count_inc(rng_count);
        if (rng_count >= cfg_trig || rng_count >= COUNT_MAX) begin
          rng_phase = PH_WAIT;
          rng_count = 0;
        end
      end
      PH_WAIT: begin
        // The rising tick counts as width one
        if (req.echo_level) begin
          rng_phase = PH_ECHO;
          rng_count = 1;
        end else begin
          rng_count   = count_inc(rng_count);
          timeout_hit = expired(rng_count);
        end
      end
      default: begin
        if (req.echo_level) begin
          rng_count   = count_inc(rng_count);
          timeout_hit = expired(rng_count);
        end else begin
          echo_fell = 1'b1;
        end
      end
    endcase
    res.trigger_level = trig;
    if (timeout_hit || echo_fell) begin
      res.result_valid = 1'b1;
      res.echo_width   = (rng_count > 64'hFFFF) ? 16'hFFFF : rng_count[15:0];
      if (timeout_hit) begin
        rng_band   = BAND_0;
        rng_status = STATUS_TIMEOUT;
      end else begin
        classify_width(rng_count);
      end
      rng_phase = PH_IDLE;
      rng_count = 0;
    end
    // Band and status always show the last finished measurement
    res.level_band = rng_band;
    res.status     = rng_status;
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      error_count++;
      if (error_count <= PRINT_LIMIT)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // Drive inputs on the falling edge. Hold a request until it is taken, then
  // advance to the next one or idle at the configured rate.
  always @(negedge clk_i) begin : tick_driver
    if (!in_valid_r || in_fire) begin
      if (tick_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_data_r  <= tick_backlog.pop_front();
        in_valid_r <= 1'b1;
      end else begin
        in_valid_r <= 1'b0;
      end
    end
    out_ready_r <= !rx_stall && ($urandom_range(99) >= rx_idle_pct);
  end

  // Hold the receiver off for a long stretch once asked, so the block fills
  always begin : rx_hold
    wait (rx_stall);
    repeat (STALL_CYCLES) @(negedge clk_i);
    rx_stall = 1'b0;
  end

  // Sample both handshakes on the rising edge: predict on every accepted
  // request, compare every accepted result with the oldest prediction.
  always @(posedge clk_i) begin : result_monitor
    ulr_out_t want;
    ulr_out_t got;
    in_fire <= in_valid_r && in_ready;
    if (in_valid_r && in_ready) begin
      ranger_step(in_data_r, want);
      predicted_results.push_back(want);
      ticks_taken++;
    end
    if (out_valid && out_ready_r) begin
      got = out_data;
      if (predicted_results.size() == 0) begin
        error_count++;
        if (error_count <= PRINT_LIMIT)
          $display("%0t: result with nothing predicted, expected none, actual %h",
                   $time, got);
      end else begin
        want = predicted_results.pop_front();
        check_field("trigger_level", want.trigger_level, got.trigger_level);
        check_field("result_valid", want.result_valid, got.result_valid);
        check_field("level_band", want.level_band, got.level_band);
        check_field("status", want.status, got.status);
        check_field("echo_width", want.echo_width, got.echo_width);
      end
    end
  end

  // End the run when neither channel moves for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_r && in_ready) || (out_valid && out_ready_r)) quiet = 0;
      else quiet++;
    end
    $display("tb_top NOT OK");
    $finish;
  end

  task automatic offer(input bit start, input bit echo);
    ulr_in_t t;
    t.start_request = start;
    t.echo_level    = echo;
    tick_backlog.push_back(t);
    ticks_offered++;
    phase_ticks++;
  endtask

  // Queue one measurement: idle gap, start, trigger pulse, echo-low wait,
  // echo-high width, falling tick. Starts while busy are random noise.
  task automatic offer_measurement(input int gap, input int wait_len, input int echo_len);
    int trig_len;
    trig_len = (cfg_trig == 8'd0) ? 1 : int'(cfg_trig);
    repeat (gap) offer(1'b0, 1'($urandom_range(1)));
    offer(1'b1, 1'($urandom_range(1)));
    repeat (trig_len - 1) offer($urandom_range(3) == 0, 1'($urandom_range(1)));
    repeat (wait_len) offer($urandom_range(3) == 0, 1'b0);
    repeat (echo_len) offer($urandom_range(3) == 0, 1'b1);
    offer($urandom_range(3) == 0, 1'b0);
  endtask

  // Wait until every queued request is taken and every result has arrived
  task automatic await_quiet();
    while (tick_backlog.size() != 0 || ticks_taken != ticks_offered ||
           predicted_results.size() != 0)
      @(negedge clk_i);
  endtask

  // Drain to an idle sequencer: finish any measurement left open by noise
  task automatic settle();
    await_quiet();
    while (rng_phase != PH_IDLE) begin
      offer(1'b0, rng_phase == PH_WAIT);
      await_quiet();
    end
  endtask

  // Write one register, then read it back in the next transfer
  task automatic reg_access(input logic [1:0] idx, input logic [15:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'd0, value};
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata !== {16'd0, value}) begin
      error_count++;
      if (error_count <= PRINT_LIMIT)
        $display("%0t: register %0d readback, expected %0d, actual %0d",
                 $time, idx, value, prdata);
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic program_ranger(input logic [7:0] trig, input logic [15:0] tmo,
                                input logic [7:0] tank, input logic [15:0] speed);
    settle();
    reg_access(REG_TRIG_TICKS, {8'd0, trig});
    reg_access(REG_ECHO_TMO, tmo);
    reg_access(REG_TANK_HEIGHT, {8'd0, tank});
    reg_access(REG_HALF_SPEED, speed);
    cfg_trig    = trig;
    cfg_timeout = tmo;
    cfg_tank    = tank;
    cfg_speed   = speed;
  endtask

  initial begin : stimulus
    logic [7:0]  trig;
    logic [15:0] tmo;
    logic [7:0]  tank;
    logic [15:0] speed;
    int          wait_len;
    int          echo_len;
    bit          paused;
    paused = 1'b0;
    send_idle_pct = 19;
    rx_idle_pct   = 45;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset values: echo is ignored while idle, then a short echo
    offer(1'b0, 1'b1);
    offer(1'b0, 1'b0);
    offer_measurement(0, 2, 3);

    // Zero trigger length and zero timeout: time out on the first counted
    // tick, once in the wait and once with echo high
    program_ranger(8'd0, 16'd0, 8'd0, 16'd0);
    offer_measurement(0, 1, 0);
    offer_measurement(0, 0, 2);

    // Empty tank: a level just below zero truncates to zero, then a
    // clearly negative level, then both timeouts
    program_ranger(8'd1, 16'd5, 8'd0, 16'd30000);
    offer_measurement(0, 0, 1);
    offer_measurement(0, 0, 3);
    offer_measurement(0, 6, 0);
    offer_measurement(0, 0, 6);

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      // Sender idles less than receiver, then the reverse, then no idling
      case (ph / 3)
        0: begin
          send_idle_pct = 19;
          rx_idle_pct   = 45;
        end
        1: begin
          send_idle_pct = 45;
          rx_idle_pct   = 19;
        end
        default: begin
          send_idle_pct = 0;
          rx_idle_pct   = 0;
        end
      endcase
      trig = ($urandom_range(7) == 0) ? 8'($urandom_range(0, 40))
                                      : 8'($urandom_range(1, 6));
      tmo  = 16'($urandom_range(8, 80));
      tank = ($urandom_range(3) == 0) ? 8'($urandom_range(0, 255))
                                      : 8'($urandom_range(0, 60));
      case ($urandom_range(3))
        0: speed = 16'hFFFF;
        1: speed = 16'($urandom_range(0, 65535));
        default: speed = 16'($urandom_range(40000, 65535));
      endcase
      // Pin a couple of phases to the tank and speed extremes
      if (ph == 1) begin
        tank  = 8'd255;
        speed = 16'd0;
      end else if (ph == 2) begin
        tank = 8'd0;
      end
      program_ranger(trig, tmo, tank, speed);
      if (ph == 0) rx_stall = 1'b1;
      phase_ticks = 0;
      while (phase_ticks < PHASE_TICKS) begin
        // Pause the sender once until every result is back
        if (ph == 4 && !paused && phase_ticks >= PHASE_TICKS / 2) begin
          await_quiet();
          paused = 1'b1;
        end
        if ($urandom_range(9) == 0) begin
          repeat ($urandom_range(4, 16))
            offer(1'($urandom_range(1)), 1'($urandom_range(1)));
        end else begin
          wait_len = ($urandom_range(4) == 0) ? $urandom_range(0, tmo + 2)
                                               : $urandom_range(0, 4);
          echo_len = ($urandom_range(4) == 0) ? $urandom_range(tmo, tmo + 2)
                                               : $urandom_range(1, tmo - 1);
          offer_measurement($urandom_range(0, 3), wait_len, echo_len);
        end
      end
    end

    // Full scale: longest trigger and widest factor with a negative level
    program_ranger(8'd255, 16'hFFFF, 8'd255, 16'hFFFF);
    offer_measurement(1, 3, 300);

    await_quiet();
    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (error_count == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
